[rtl/core/direct_mapped_write_through_cache_unit_assert.svh]
// assertion macros for the direct mapped write-through cache unit
// expects clk and rst_n in the scope of every use
`ifndef DIRECT_MAPPED_WRITE_THROUGH_CACHE_UNIT_ASSERT_SVH
`define DIRECT_MAPPED_WRITE_THROUGH_CACHE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DMWC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DMWC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMWC_ASSERT_IMP(name, ante, cons, msg)
`define DMWC_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

[rtl/core/dmwc_pkg.sv]
// shared sizes, beat types and controller states for the cache unit
// no dependencies
`timescale 1ns / 1ps

package dmwc_pkg;

  localparam int MEM_WORDS   = 1024;
  localparam int CACHE_WORDS = 64;
  localparam int BLOCK_WORDS = 4;
  localparam int NUM_LINES   = CACHE_WORDS / BLOCK_WORDS;

  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int CIDX_W = $clog2(CACHE_WORDS);
  localparam int WORD_W = $clog2(BLOCK_WORDS);
  localparam int LINE_W = CIDX_W - WORD_W;
  localparam int TAG_W  = ADDR_W - CIDX_W;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_FILL,
    ST_DRAIN,
    ST_DONE
  } st_t;

  typedef struct packed {
    cmd_t                     command;
    logic        [ADDR_W-1:0] address;
    logic signed [DATA_W-1:0] write_value;
  } in_beat_t;

  typedef struct packed {
    logic                     hit;
    logic        [TAG_W-1:0]  tag_out;
    logic        [LINE_W-1:0] line_out;
    logic        [WORD_W-1:0] word_out;
    logic signed [DATA_W-1:0] data_out;
  } out_beat_t;

  typedef struct packed {
    logic              upd;
    logic [LINE_W-1:0] line;
    logic [TAG_W-1:0]  tag;
  } tag_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [CIDX_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } cache_req_t;

endpackage

[rtl/core/dmwc_chan_if.sv]
// valid/ready channel carrying one payload beat of type T
// used for both the request and the result side; no dependencies
`timescale 1ns / 1ps

interface dmwc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/dmwc_ram.sv]
// generic single-port synchronous ram, registered read
// no dependencies; read data holds while re is low
`timescale 1ns / 1ps

module dmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q_r <= mem[addr];
    end
  end

  assign q = q_r;

endmodule

[rtl/core/dmwc_tags.sv]
// line valid bits and stored tags with the hit compare
// depends on dmwc_pkg
`timescale 1ns / 1ps

module dmwc_tags import dmwc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tag_req_t req,
  output logic     hit
);

  logic [NUM_LINES-1:0] valid_r;
  logic [TAG_W-1:0]     tag_r [NUM_LINES];

  assign hit = valid_r[req.line] && (tag_r[req.line] == req.tag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.upd) begin
      valid_r[req.line] <= 1'b1;
    end
  end

  // tags are only compared behind a set valid bit
  always_ff @(posedge clk) begin
    if (req.upd) begin
      tag_r[req.line] <= req.tag;
    end
  end

endmodule

[rtl/core/dmwc_seq.sv]
// access sequencer: memory init sweep, lookup, block refill, write-through
// and the result register; depends on dmwc_pkg
`timescale 1ns / 1ps

module dmwc_seq import dmwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data,
  output tag_req_t          tag_req,
  input  logic              tag_hit,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] mem_q,
  output cache_req_t        cache_req,
  input  logic [DATA_W-1:0] cache_q
);

  st_t               st_r, st_nxt;
  logic [ADDR_W-1:0] init_r;
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] val_r;
  logic              hit_r;
  logic [WORD_W-1:0] k_r;
  logic              rd_vld_r;
  logic [WORD_W-1:0] rd_k_r;
  logic [DATA_W-1:0] data_r;
  logic              use_cq_r;
  logic              out_valid_r;
  out_beat_t         out_r;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              is_wr;
  logic [LINE_W-1:0] line;
  logic [TAG_W-1:0]  tag;
  logic [WORD_W-1:0] word;
  logic [DATA_W-1:0] fill_word;

  assign line  = addr_r[CIDX_W-1:WORD_W];
  assign tag   = addr_r[ADDR_W-1:CIDX_W];
  assign word  = addr_r[WORD_W-1:0];
  assign is_wr = (cmd_r == CMD_WRITE);

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // a write miss puts its own value into the refilled block
  assign fill_word = (is_wr && (rd_k_r == word)) ? val_r : mem_q;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_INIT: begin
        if (init_r == ADDR_W'(MEM_WORDS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        st_nxt = tag_hit ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        if (k_r == WORD_W'(BLOCK_WORDS - 1)) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and memory ports
  always_comb begin
    in_ready     = 1'b0;
    load_out     = 1'b0;
    tag_req.upd  = 1'b0;
    tag_req.line = line;
    tag_req.tag  = tag;

    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = addr_r;
    mem_req.wdata = val_r;

    // refill data lands in the cycle after each main read
    cache_req.we    = rd_vld_r;
    cache_req.re    = 1'b0;
    cache_req.addr  = rd_vld_r ? {line, rd_k_r} : addr_r[CIDX_W-1:0];
    cache_req.wdata = rd_vld_r ? fill_word : val_r;

    case (st_r)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = init_r;
        mem_req.wdata = DATA_W'(MEM_WORDS) - DATA_W'(init_r);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOK: begin
        tag_req.upd  = !tag_hit;
        cache_req.re = !is_wr;
        cache_req.we = tag_hit && is_wr;
        mem_req.we   = tag_hit && is_wr;
      end
      ST_FILL: begin
        mem_req.re   = 1'b1;
        mem_req.addr = {addr_r[ADDR_W-1:WORD_W], k_r};
      end
      ST_DRAIN: begin
        mem_req.we = is_wr;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      init_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= (st_r == ST_FILL);
      if (st_r == ST_INIT) begin
        init_r <= init_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.command;
      addr_r <= in_data.address;
      val_r  <= in_data.write_value;
    end
    if (st_r == ST_LOOK) begin
      hit_r    <= tag_hit;
      use_cq_r <= tag_hit && !is_wr;
      data_r   <= val_r;
      k_r      <= '0;
    end
    if (st_r == ST_FILL) begin
      k_r    <= k_r + 1'b1;
      rd_k_r <= k_r;
    end
    if (rd_vld_r && (rd_k_r == word)) begin
      data_r <= fill_word;
    end
    if (load_out) begin
      out_r.hit      <= hit_r;
      out_r.tag_out  <= tag;
      out_r.line_out <= line;
      out_r.word_out <= word;
      out_r.data_out <= use_cq_r ? cache_q : data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/direct_mapped_write_through_cache_unit.sv]
// top level of the direct mapped write-through, write-allocate cache
// depends on dmwc_pkg, dmwc_chan_if, dmwc_ram, dmwc_tags, dmwc_seq
//
//  channel  dir  beat type   fields
//  in_bus   in   in_beat_t   command, address, write_value
//  out_bus  out  out_beat_t  hit, tag_out, line_out, word_out, data_out
//
// a hit goes from lookup to done; a miss first refills its block with the
// one-word-per-cycle refill through the single main memory port, then drains
// after reset the main memory is swept to its start values,
// with in_bus.ready low
// the result sits in an output register; a stalled result holds the next
// access in its final cycle
`timescale 1ns / 1ps
`include "direct_mapped_write_through_cache_unit_assert.svh"

module direct_mapped_write_through_cache_unit import dmwc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  dmwc_chan_if.sink   in_bus,
  dmwc_chan_if.source out_bus
);

  tag_req_t          tag_req;
  logic              tag_hit;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_q;
  cache_req_t        cache_req;
  logic [DATA_W-1:0] cache_q;
  logic              in_ready;
  logic              out_valid;
  out_beat_t         out_data;

  dmwc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .in_data   (in_bus.data),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .out_data  (out_data),
    .tag_req   (tag_req),
    .tag_hit   (tag_hit),
    .mem_req   (mem_req),
    .mem_q     (mem_q),
    .cache_req (cache_req),
    .cache_q   (cache_q)
  );

  dmwc_tags u_tags (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tag_req),
    .hit   (tag_hit)
  );

  dmwc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_main_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .q     (mem_q)
  );

  dmwc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CACHE_WORDS)
  ) u_line_ram (
    .clk   (clk),
    .we    (cache_req.we),
    .re    (cache_req.re),
    .addr  (cache_req.addr),
    .wdata (cache_req.wdata),
    .q     (cache_q)
  );

  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid;
  assign out_bus.data  = out_data;

  // a refilled line must hit straight after its tag update
  `DMWC_ASSERT_NXT(a_upd_then_hit, tag_req.upd, tag_hit, "line not valid after tag update")
  // tags are replaced only on a miss
  `DMWC_ASSERT_IMP(a_upd_on_miss, tag_req.upd, !tag_hit, "tag update on a hit")
  // no second access is taken while one is in flight
  `DMWC_ASSERT_NXT(a_busy_after_accept, in_bus.valid && in_ready, !in_ready, "accept while busy")

endmodule

[dv/direct_mapped_write_through_cache_unit_tb.sv]
// testbench for the direct mapped write-through cache unit: directed and random
// accesses, a shadow cache and main memory predict every result beat
// depends on dmwc_pkg, dmwc_chan_if and the cache unit rtl
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_unit_tb import dmwc_pkg::*; ();

  logic clk;
  logic rst_n;

  dmwc_chan_if #(.T(in_beat_t))  in_if ();
  dmwc_chan_if #(.T(out_beat_t)) out_if ();

  direct_mapped_write_through_cache_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  // shadow copies of main memory and the cache
  logic [DATA_W-1:0] mem_image   [MEM_WORDS];
  logic              line_live   [NUM_LINES];
  logic [TAG_W-1:0]  line_tag_m  [NUM_LINES];
  logic [DATA_W-1:0] cached_word [CACHE_WORDS];

  in_beat_t  access_q[$];
  out_beat_t result_q[$];

  int err_cnt;
  int accepted_cnt;
  int cyc;
  int hold_left;
  logic hold_done;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_beat_t predict_access(in_beat_t b);
    logic [TAG_W-1:0]  t;
    logic [LINE_W-1:0] l;
    logic [WORD_W-1:0] w;
    logic [CIDX_W-1:0] slot;
    logic [ADDR_W-1:0] base;
    logic              hit_now;
    out_beat_t         r;
    int                i;
    t = b.address[ADDR_W-1:CIDX_W];
    l = b.address[CIDX_W-1:WORD_W];
    w = b.address[WORD_W-1:0];
    slot = {l, {WORD_W{1'b0}}};
    base = {t, l, {WORD_W{1'b0}}};
    hit_now = line_live[l] && (line_tag_m[l] == t);
    if (!hit_now) begin
      line_live[l] = 1'b1;
      line_tag_m[l] = t;
      for (i = 0; i < BLOCK_WORDS; i++)
        cached_word[slot + i] = mem_image[base + i];
    end
    if (b.command == CMD_WRITE) begin
      cached_word[slot + w] = b.write_value;
      mem_image[b.address] = b.write_value;
    end
    r.hit = hit_now;
    r.tag_out = t;
    r.line_out = l;
    r.word_out = w;
    r.data_out = cached_word[slot + w];
    return r;
  endfunction

  task automatic add_access(cmd_t c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] v);
    in_beat_t b;
    b.command = c;
    b.address = a;
    b.write_value = v;
    access_q.push_back(b);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // a long window in which neither side idles
  function automatic logic quiet_window();
    return (cyc >= 6000) && (cyc < 9000);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) cyc <= 0;
    else cyc <= cyc + 1;
  end

  // sender: a new beat may go out whenever the slot is free, always in the quiet window
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (access_q.size() != 0 && (quiet_window() || $urandom_range(99) >= 19)) begin
        in_if.valid <= 1'b1;
        in_if.data <= access_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, sender keeps offering so the unit backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= 800) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= (hold_left == 0) && (quiet_window() || $urandom_range(99) >= 19);
  end

  // result check, then prediction for the beat taken at this edge
  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            err_cnt++;
          end
          if (got.tag_out !== want.tag_out) begin
            $display("%0t: tag_out expected %0h actual %0h", $time, want.tag_out,
                     got.tag_out);
            err_cnt++;
          end
          if (got.line_out !== want.line_out) begin
            $display("%0t: line_out expected %0h actual %0h", $time, want.line_out,
                     got.line_out);
            err_cnt++;
          end
          if (got.word_out !== want.word_out) begin
            $display("%0t: word_out expected %0h actual %0h", $time, want.word_out,
                     got.word_out);
            err_cnt++;
          end
          if (got.data_out !== want.data_out) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data_out,
                     got.data_out);
            err_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(predict_access(in_if.data));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int i;
    int r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] last_a;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    err_cnt = 0;
    accepted_cnt = 0;
    for (i = 0; i < MEM_WORDS; i++) mem_image[i] = MEM_WORDS - i;
    for (i = 0; i < NUM_LINES; i++) begin
      line_live[i] = 1'b0;
      line_tag_m[i] = '0;
    end
    for (i = 0; i < CACHE_WORDS; i++) cached_word[i] = '0;

    // directed part: cold lines with a zero tag, extremes, conflicts, write-allocate
    add_access(CMD_READ,  10'd0,    32'h0);
    add_access(CMD_READ,  10'd1,    32'h0);
    add_access(CMD_READ,  10'd4,    32'hffff_ffff);
    add_access(CMD_READ,  10'd1023, 32'h0);
    add_access(CMD_WRITE, 10'd1023, 32'h7fff_ffff);
    add_access(CMD_READ,  10'd1023, 32'h0);
    add_access(CMD_WRITE, 10'd2,    32'h8000_0000);
    add_access(CMD_READ,  10'd66,   32'h0);
    add_access(CMD_READ,  10'd2,    32'h0);
    add_access(CMD_WRITE, 10'd512,  32'hffff_ffff);
    add_access(CMD_READ,  10'd512,  32'h0);
    add_access(CMD_READ,  10'd3,    32'hdead_beef);
    add_access(CMD_WRITE, 10'd5,    32'h0000_0000);
    add_access(CMD_WRITE, 10'd1000, 32'h1234_5678);
    add_access(CMD_READ,  10'd936,  32'h0);
    add_access(CMD_READ,  10'd1000, 32'h0);
    add_access(CMD_WRITE, 10'd960,  32'h5555_aaaa);
    add_access(CMD_WRITE, 10'd961,  32'haaaa_5555);
    add_access(CMD_WRITE, 10'd962,  32'h0000_0001);
    add_access(CMD_WRITE, 10'd963,  32'hfffe_ffff);
    add_access(CMD_READ,  10'd960,  32'h0);
    add_access(CMD_READ,  10'd682,  32'h0);

    // random part: mostly a small tag pool so lines hit and conflict often
    last_a = '0;
    for (i = 0; i < 1700; i++) begin
      r = $urandom_range(99);
      if (r < 15) a = ADDR_W'($urandom_range(MEM_WORDS - 1));
      else if (r < 75) a = {TAG_W'($urandom_range(3)), LINE_W'($urandom),
                            WORD_W'($urandom)};
      else a = {last_a[ADDR_W-1:WORD_W], WORD_W'($urandom)};
      add_access($urandom_range(99) < 45 ? CMD_WRITE : CMD_READ, a, pick_value());
      last_a = a;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (access_q.size() != 0 || in_if.valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
